[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define UKT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define UKT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UKT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UKT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/ukt_pkg.sv]
// ----------------------------------------------------------------------------
// ukt_pkg
// shared constants, codes and control/status types of the key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ukt_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 4;
  localparam int ENT_W  = 5;
  localparam int CAP_W  = 5;

  localparam int ENTRY_W = KEY_W + VAL_W;

  localparam int IN_BITS      = OP_W + KEY_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = ST_W + SLOT_W + VAL_W + ENT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_IDX_W = CFG_AW - 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_INSERT,
    S_POST
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    scan_step;
    logic    rd_next;
    logic    rd_last;
    logic    write_new;
    logic    write_move;
    logic    set_res;
    status_t res_code;
    logic    slot_from_count;
    logic    take_value;
    logic    post;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic hit;
    logic scan_end;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/ukt_ram.sv]
// ----------------------------------------------------------------------------
// ukt_ram
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ukt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ukt_ctrl.sv]
// ----------------------------------------------------------------------------
// ukt_ctrl
// sequencer for insert, find and delete over the key table datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ukt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ukt_pkg::dp_stat_t  stat,
  output ukt_pkg::ctrl_cmd_t cmd
);

  ukt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ukt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ukt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ukt_pkg::S_DECODE;
      end
      ukt_pkg::S_DECODE: begin
        case (stat.op)
          ukt_pkg::OP_INSERT: begin
            if (stat.full) state_nxt = ukt_pkg::S_POST;
            else if (stat.empty) state_nxt = ukt_pkg::S_INSERT;
            else state_nxt = ukt_pkg::S_SCAN;
          end
          ukt_pkg::OP_FIND, ukt_pkg::OP_DELETE: begin
            state_nxt = stat.empty ? ukt_pkg::S_POST : ukt_pkg::S_SCAN;
          end
          default: state_nxt = ukt_pkg::S_POST;
        endcase
      end
      ukt_pkg::S_SCAN: begin
        if (stat.hit) begin
          state_nxt = (stat.op == ukt_pkg::OP_DELETE) ? ukt_pkg::S_LAST : ukt_pkg::S_POST;
        end else if (stat.scan_end) begin
          state_nxt = (stat.op == ukt_pkg::OP_INSERT) ? ukt_pkg::S_INSERT : ukt_pkg::S_POST;
        end
      end
      ukt_pkg::S_LAST:   state_nxt = ukt_pkg::S_MOVE;
      ukt_pkg::S_MOVE:   state_nxt = ukt_pkg::S_POST;
      ukt_pkg::S_INSERT: state_nxt = ukt_pkg::S_POST;
      ukt_pkg::S_POST: begin
        if (stat.out_free) state_nxt = ukt_pkg::S_IDLE;
      end
      default: state_nxt = ukt_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ukt_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
      end
      ukt_pkg::S_DECODE: begin
        case (stat.op)
          ukt_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ukt_pkg::ST_FULL;
            end
          end
          ukt_pkg::OP_FIND, ukt_pkg::OP_DELETE: begin
            if (stat.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ukt_pkg::ST_MISS;
            end
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ukt_pkg::ST_MISS;
          end
        endcase
      end
      ukt_pkg::S_SCAN: begin
        cmd.rd_next = 1'b1;
        if (stat.hit) begin
          case (stat.op)
            ukt_pkg::OP_INSERT: begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ukt_pkg::ST_DUP;
            end
            ukt_pkg::OP_FIND: begin
              cmd.set_res    = 1'b1;
              cmd.res_code   = ukt_pkg::ST_OK;
              cmd.take_value = 1'b1;
            end
            ukt_pkg::OP_DELETE: ;
            default: begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ukt_pkg::ST_MISS;
            end
          endcase
        end else if (stat.scan_end) begin
          if (stat.op != ukt_pkg::OP_INSERT) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ukt_pkg::ST_MISS;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ukt_pkg::S_LAST: begin
        cmd.rd_last = 1'b1;
      end
      ukt_pkg::S_MOVE: begin
        cmd.write_move = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_code   = ukt_pkg::ST_OK;
      end
      ukt_pkg::S_INSERT: begin
        cmd.write_new       = 1'b1;
        cmd.set_res         = 1'b1;
        cmd.res_code        = ukt_pkg::ST_OK;
        cmd.slot_from_count = 1'b1;
      end
      ukt_pkg::S_POST: begin
        cmd.post = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/ukt_dp.sv]
// ----------------------------------------------------------------------------
// ukt_dp
// key table datapath: entry ram, scan index, live count and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ukt_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ukt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [ukt_pkg::CAP_W-1:0]          cap,
  input  ukt_pkg::ctrl_cmd_t                 cmd,
  output ukt_pkg::dp_stat_t                  stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ukt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int KEY_LO = ukt_pkg::OP_W;
  localparam int VAL_LO = ukt_pkg::OP_W + ukt_pkg::KEY_W;

  ukt_pkg::op_t                     op_r;
  logic [ukt_pkg::KEY_W-1:0]        key_r;
  logic [ukt_pkg::VAL_W-1:0]        val_r;
  logic [ukt_pkg::CNT_W-1:0]        count_r;
  logic [ukt_pkg::IDX_W-1:0]        idx_r;
  ukt_pkg::status_t                 res_status_r;
  logic [ukt_pkg::SLOT_W-1:0]       res_slot_r;
  logic [ukt_pkg::VAL_W-1:0]        res_value_r;
  logic                             out_valid_r;
  logic [ukt_pkg::OUT_TDATA_W-1:0]  out_data_r;

  logic                             ram_we;
  logic [ukt_pkg::IDX_W-1:0]        ram_waddr;
  logic [ukt_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [ukt_pkg::IDX_W-1:0]        ram_raddr;
  logic [ukt_pkg::ENTRY_W-1:0]      ram_rdata;
  logic [ukt_pkg::KEY_W-1:0]        rd_key;
  logic [ukt_pkg::VAL_W-1:0]        rd_value;
  logic [ukt_pkg::SLOT_W-1:0]       slot_sel;

  // entry layout: key in the low half, value in the high half
  assign rd_key   = ram_rdata[ukt_pkg::KEY_W-1:0];
  assign rd_value = ram_rdata[ukt_pkg::ENTRY_W-1:ukt_pkg::KEY_W];

  // read address: next slot while scanning, last live slot before a move
  always_comb begin
    if (cmd.rd_last) begin
      ram_raddr = ukt_pkg::IDX_W'(count_r - ukt_pkg::CNT_W'(1));
    end else if (cmd.rd_next) begin
      ram_raddr = idx_r + ukt_pkg::IDX_W'(1);
    end else begin
      ram_raddr = '0;
    end
  end

  assign ram_we    = cmd.write_new | cmd.write_move;
  assign ram_waddr = cmd.write_move ? idx_r : ukt_pkg::IDX_W'(count_r);
  assign ram_wdata = cmd.write_move ? ram_rdata : {val_r, key_r};

  ukt_ram #(
    .WIDTH (ukt_pkg::ENTRY_W),
    .DEPTH (ukt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write_new) begin
        count_r <= count_r + ukt_pkg::CNT_W'(1);
      end else if (cmd.write_move) begin
        count_r <= count_r - ukt_pkg::CNT_W'(1);
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  function automatic logic res_code_ok();
    return cmd.res_code == ukt_pkg::ST_OK;
  endfunction

  always_comb begin
    if (res_code_ok()) begin
      slot_sel = cmd.slot_from_count ? ukt_pkg::SLOT_W'(count_r) : ukt_pkg::SLOT_W'(idx_r);
    end else begin
      slot_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= ukt_pkg::op_t'(in_tdata[ukt_pkg::OP_W-1:0]);
      key_r <= in_tdata[KEY_LO +: ukt_pkg::KEY_W];
      val_r <= in_tdata[VAL_LO +: ukt_pkg::VAL_W];
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + ukt_pkg::IDX_W'(1);
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_slot_r   <= slot_sel;
      res_value_r  <= cmd.take_value ? rd_value : '0;
    end
    if (cmd.post) begin
      out_data_r <= ukt_pkg::OUT_TDATA_W'({ukt_pkg::ENT_W'(count_r), res_value_r,
                                           res_slot_r, res_status_r});
    end
  end

  always_comb begin
    stat.op       = op_r;
    // limit is min(capacity, DEPTH)
    stat.full     = (32'(count_r) >= 32'(cap)) || (32'(count_r) >= 32'(ukt_pkg::DEPTH));
    stat.empty    = (count_r == '0);
    stat.hit      = (rd_key == key_r);
    stat.scan_end = ((ukt_pkg::CNT_W'(idx_r) + ukt_pkg::CNT_W'(1)) == count_r);
    stat.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/unordered_key_table.sv]
// ----------------------------------------------------------------------------
// unordered_key_table
// Compact unordered key/value table of 16 entries kept in slots 0 to count-1.
// Each request is an insert, find or delete and yields exactly one result.
// One request is worked at a time: after acceptance it is decoded, then the
// live slots are compared one at a time by a linear key scan (the single
// read port of the entry ram sets this), then a new key is written for an
// insert, or for a delete the last entry is read and moved into the hole,
// and then the result is posted; a refused or trivially missed request goes
// from decode straight to the post. A posted result sits in the output
// register until taken; a new request is accepted once the previous one has
// been posted. Capacity is set over the apb port at byte address 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module unordered_key_table (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: operation [1:0], key [33:2], value [65:34], zero pad above
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ukt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: status [1:0], slot [5:2], found_value [37:6], entries [42:38]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ukt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ukt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [ukt_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [ukt_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  logic [ukt_pkg::CAP_W-1:0]     cap_r;
  logic [ukt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                          cfg_wr;
  ukt_pkg::ctrl_cmd_t            cmd;
  ukt_pkg::dp_stat_t             stat;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ukt_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ukt_pkg::CAP_RESET;
    end else if (cfg_wr && (cfg_idx == ukt_pkg::REG_CAPACITY)) begin
      cap_r <= cfg_pwdata[ukt_pkg::CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_idx == ukt_pkg::REG_CAPACITY) ? ukt_pkg::CFG_DW'(cap_r) : '0;

  ukt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ukt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cap        (cap_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // result field views for checking
  logic [ukt_pkg::ST_W-1:0]   chk_status;
  logic [ukt_pkg::SLOT_W-1:0] chk_slot;
  logic [ukt_pkg::VAL_W-1:0]  chk_value;

  assign chk_status = out_tdata[ukt_pkg::ST_W-1:0];
  assign chk_slot   = out_tdata[ukt_pkg::ST_W +: ukt_pkg::SLOT_W];
  assign chk_value  = out_tdata[ukt_pkg::ST_W + ukt_pkg::SLOT_W +: ukt_pkg::VAL_W];

  // a refused or missed request reports slot zero
  `UKT_ASSERT_IMP(a_slot_zero_on_fail, clk, rst_n,
                  out_tvalid && (chk_status != ukt_pkg::ST_OK), chk_slot == '0)
  // only a successful find carries a value
  `UKT_ASSERT_IMP(a_value_only_on_ok, clk, rst_n,
                  out_tvalid && (chk_value != '0), chk_status == ukt_pkg::ST_OK)
  // one request at a time: busy right after acceptance
  `UKT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

[test/key_table_checker.sv]
// ----------------------------------------------------------------------------
// key_table_checker
// Watches the request, result and apb channels of the key table, keeps its
// own copy of the table and capacity, predicts one result per accepted
// request and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_table_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // in_tdata: operation, key, value, zero pad
  input  logic [ukt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: status, slot, found_value, entries, zero pad
  input  logic [ukt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ukt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [ukt_pkg::CFG_DW-1:0]       cfg_pwdata,
  input  logic [ukt_pkg::CFG_DW-1:0]       cfg_prdata,
  input  logic                             cfg_pready,
  output int                               mismatches,
  output int                               pending
);

  import ukt_pkg::*;

  localparam int REPORT_MAX = 10;

  // lowest field last, so the struct maps straight onto out_tdata
  typedef struct packed {
    logic [ENT_W-1:0]  entries;
    logic [VAL_W-1:0]  found_value;
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } table_result_t;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  int               live_n;
  logic [CAP_W-1:0] cap_q;
  table_result_t    expected_results[$];

  function automatic int slot_of_key(input logic [KEY_W-1:0] key);
    for (int i = 0; i < live_n; i++) begin
      if (key_mem[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic apply_table_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val, output table_result_t res);
    int lim;
    int hit;
    lim = (cap_q > DEPTH) ? DEPTH : int'(cap_q);
    hit = slot_of_key(key);
    res.status      = ST_MISS;
    res.slot        = '0;
    res.found_value = '0;
    case (op)
      OP_INSERT: begin
        // the limit is checked ahead of the duplicate search
        if (live_n >= lim) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_DUP;
        end else begin
          key_mem[live_n] = key;
          val_mem[live_n] = val;
          res.slot   = SLOT_W'(live_n);
          res.status = ST_OK;
          live_n++;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          res.status      = ST_OK;
          res.slot        = SLOT_W'(hit);
          res.found_value = val_mem[hit];
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          // last live entry moves into the hole
          key_mem[hit] = key_mem[live_n-1];
          val_mem[hit] = val_mem[live_n-1];
          live_n--;
          res.status = ST_OK;
          res.slot   = SLOT_W'(hit);
        end
      end
      default: ;
    endcase
    res.entries = ENT_W'(live_n);
  endtask

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    table_result_t got;
    table_result_t exp;
    table_result_t res;
    if (!rst_n) begin
      live_n     = 0;
      cap_q      = CAP_RESET;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_BITS-1:0];
        if (expected_results.size() == 0) begin
          note_error($sformatf("unexpected result: status=%0d slot=%0d value=%h entries=%0d",
                               got.status, got.slot, got.found_value, got.entries));
        end else begin
          exp = expected_results.pop_front();
          if (got.status !== exp.status || got.slot !== exp.slot ||
              got.found_value !== exp.found_value || got.entries !== exp.entries) begin
            note_error($sformatf({"result mismatch: expected status=%0d slot=%0d value=%h ",
                                  "entries=%0d, got status=%0d slot=%0d value=%h entries=%0d"},
                                 exp.status, exp.slot, exp.found_value, exp.entries,
                                 got.status, got.slot, got.found_value, got.entries));
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_CAPACITY) begin
        if (cfg_pwrite) begin
          cap_q = cfg_pwdata[CAP_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(cap_q)) begin
          note_error($sformatf("capacity readback: expected %h, got %h",
                               CFG_DW'(cap_q), cfg_prdata));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_table_op(in_tdata[OP_W-1:0], in_tdata[OP_W +: KEY_W],
                       in_tdata[OP_W+KEY_W +: VAL_W], res);
        expected_results.push_back(res);
      end
    end
    pending = expected_results.size();
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Key table testbench: a directed opening over empty, full and clamped
// tables, then phases of random insert/find/delete traffic on a small key
// pool at several capacities, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import ukt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 30;
  localparam int N_PHASES     = 9;
  localparam int POOL_N       = 24;
  localparam int PHASE_ITEMS  = 160;

  localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 1'b1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int                     mismatches;
  int                     pending;
  int                     cycles;
  int                     stall_left;
  bit                     quiet_run;
  logic [KEY_W-1:0]       key_pool [POOL_N];

  int phase_cap     [N_PHASES] = '{16, 1, 31, 0, 8, 17, 5, 16, 3};
  int phase_ins_pct [N_PHASES] = '{45, 50, 60, 30, 40, 55, 35, 20, 50};

  unordered_key_table u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  key_table_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side backpressure
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet_run || stall_left == 0) begin
        out_tready <= 1'b1;
        if (!quiet_run && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end else begin
        out_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  // called and returns at a falling edge
  task automatic push_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    int gap;
    gap = (!quiet_run && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, val, key, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // the bus idles between transfers
    @(negedge clk);
  endtask

  // junk in the upper data bits, then read back
  task automatic set_capacity(input int cap);
    logic [CFG_DW-1:0] word;
    wait_idle();
    word = ($urandom & ~CFG_DW'({CAP_W{1'b1}})) | CFG_DW'(cap);
    cfg_access(1'b1, REG_CAPACITY, word);
    cfg_access(1'b0, REG_CAPACITY, '0);
  endtask

  task automatic random_request(input int ins_pct);
    int r;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 3) op = OP_UNUSED;
    else if (r < 3 + ins_pct) op = OP_INSERT;
    else if ($urandom_range(0, 99) < 55) op = OP_FIND;
    else op = OP_DELETE;
    // pool keys give hits, duplicates and a full table; some stray keys too
    key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, POOL_N-1)];
    r = $urandom_range(0, 19);
    val = (r == 0) ? '0 : (r == 1) ? '1 : VAL_W'($urandom);
    push_request(op, key, val);
  endtask

  initial begin
    int n_items;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cycles      = 0;
    quiet_run   = 1'b0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < POOL_N; k++) key_pool[k] = $urandom;
    phase_cap[6] = $urandom_range(2, 15);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // write to an unmapped register must leave capacity at its reset value
    cfg_access(1'b1, REG_SPARE, 32'h1);
    cfg_access(1'b0, REG_CAPACITY, '0);

    push_request(OP_FIND,   key_pool[2], '0);
    push_request(OP_DELETE, key_pool[2], '0);
    push_request(OP_UNUSED, key_pool[0], '1);
    push_request(OP_INSERT, key_pool[0], '0);
    push_request(OP_INSERT, key_pool[1], '1);
    push_request(OP_INSERT, key_pool[0], $urandom);
    push_request(OP_FIND,   key_pool[1], '0);
    for (int k = 2; k < DEPTH; k++) push_request(OP_INSERT, key_pool[k], $urandom);
    // full table wins over duplicate key
    push_request(OP_INSERT, key_pool[0], $urandom);
    // capacity below the live count keeps entries, refuses inserts
    set_capacity(4);
    push_request(OP_INSERT, key_pool[DEPTH], $urandom);
    push_request(OP_DELETE, key_pool[DEPTH-1], '0);
    push_request(OP_DELETE, key_pool[0], '0);
    push_request(OP_FIND,   key_pool[DEPTH-2], '0);
    push_request(OP_UNUSED, key_pool[1], $urandom);

    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(phase_cap[p]);
      quiet_run = (p == 2);
      n_items = (phase_cap[p] == 0) ? 50 : PHASE_ITEMS;
      for (int i = 0; i < n_items; i++) begin
        if (p == 4 && i == n_items / 2) wait_idle();
        random_request(phase_ins_pct[p]);
      end
    end
    quiet_run = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ukt_pkg.sv
rtl/ukt_ram.sv
rtl/ukt_ctrl.sv
rtl/ukt_dp.sv
rtl/unordered_key_table.sv
test/key_table_checker.sv
test/tb.sv
